/* rtl/core/sbur_pkg.sv */
// Shared types, codes and defaults of the sequenced block upload receiver.
package sbur_pkg;

  localparam int FRAMES_IN_BLOCK_DEF = 128;
  localparam int BYTES_IN_FRAME_DEF  = 7;

  // Action codes of an input item.
  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_DATA   = 3'd1,
    ACT_END    = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_FINISH = 3'd4
  } action_t;

  // Pending operation; the same codes go out as request_kind.
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_BLOCK  = 2'd1,
    PEND_FINAL  = 2'd2,
    PEND_FINISH = 2'd3
  } pend_t;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ACK  = 2'd1,
    RPL_NACK = 2'd2
  } reply_t;

  // Bit positions in the error flags.
  localparam int FLAG_SEQ   = 0;
  localparam int FLAG_BAD   = 1;
  localparam int FLAG_WRITE = 2;

  typedef struct packed {
    logic [2:0]  action;
    logic        reply_wanted;
    logic [3:0]  frame_length;
    logic [7:0]  seq_byte;
    logic        outcome_ok;
    logic [15:0] outcome_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [7:0]  reply_seq;
    logic [9:0]  store_offset;
    logic [2:0]  store_len;
    logic [1:0]  request_kind;
    logic [9:0]  write_len;
    logic        upload_active;
    logic [2:0]  error_bits;
    logic [7:0]  next_seq;
    logic [9:0]  fill_count;
    logic [15:0] block_count;
    logic [15:0] last_fault;
  } out_item_t;

endpackage

/* rtl/core/sbur_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface sbur_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        reply_wanted;
  logic [3:0]  frame_length;
  logic [7:0]  seq_byte;
  logic        outcome_ok;
  logic [15:0] outcome_code;

  modport source (
    output valid, action, reply_wanted, frame_length, seq_byte, outcome_ok, outcome_code,
    input  ready
  );
  modport sink (
    input  valid, action, reply_wanted, frame_length, seq_byte, outcome_ok, outcome_code,
    output ready
  );
endinterface

interface sbur_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [7:0]  reply_seq;
  logic [9:0]  store_offset;
  logic [2:0]  store_len;
  logic [1:0]  request_kind;
  logic [9:0]  write_len;
  logic        upload_active;
  logic [2:0]  error_bits;
  logic [7:0]  next_seq;
  logic [9:0]  fill_count;
  logic [15:0] block_count;
  logic [15:0] last_fault;

  modport source (
    output valid, reply_kind, reply_seq, store_offset, store_len, request_kind, write_len,
           upload_active, error_bits, next_seq, fill_count, block_count, last_fault,
    input  ready
  );
  modport sink (
    input  valid, reply_kind, reply_seq, store_offset, store_len, request_kind, write_len,
           upload_active, error_bits, next_seq, fill_count, block_count, last_fault,
    output ready
  );
endinterface

/* rtl/core/sequenced_block_upload_receiver.sv */
// Top level of the sequenced block upload receiver.
//
// Follows a firmware image that arrives as numbered bus frames and gives exactly one
// result item per input item. A data frame is checked for length and sequence; an
// accepted frame reports the buffer offset and length of its payload, and the frame
// that completes a block raises a block write request whose ack or nack waits for the
// write outcome. End requests raise a final partial write and/or a finish request.
// Outside outcomes (start, write, finish) come back as input items; while a write or
// finish is pending every other item only reports status. An item is held in the input
// register, and its result is loaded into the output register when the item is
// evaluated; one item is accepted every cycle while results are taken, and the upload
// state in the engine advances as each item is evaluated. A waiting result
// stalls the input only when both the input and output registers are full.
module sequenced_block_upload_receiver #(
  parameter int FRAMES_IN_BLOCK = sbur_pkg::FRAMES_IN_BLOCK_DEF,
  parameter int BYTES_IN_FRAME  = sbur_pkg::BYTES_IN_FRAME_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sbur_in_if.sink   in_if,
  sbur_out_if.source out_if
);

  logic                in_v_r;
  sbur_pkg::in_item_t  in_item_r;
  logic                out_v_r;
  sbur_pkg::out_item_t out_item_r;
  sbur_pkg::out_item_t eng_res;
  logic                out_adv;
  logic                fire;

  // Output register is free when empty or being drained this cycle.
  assign out_adv = !out_v_r || out_if.ready;
  // Evaluate the held item when its result has a place to go.
  assign fire    = in_v_r && out_adv;
  // Take a new item whenever the input register empties this cycle.
  assign in_if.ready = !in_v_r || out_adv;

  // Input register: hold the item until it is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r.action       <= in_if.action;
      in_item_r.reply_wanted <= in_if.reply_wanted;
      in_item_r.frame_length <= in_if.frame_length;
      in_item_r.seq_byte     <= in_if.seq_byte;
      in_item_r.outcome_ok   <= in_if.outcome_ok;
      in_item_r.outcome_code <= in_if.outcome_code;
    end
  end

  // State and decisions; the upload state advances only on fire.
  sbur_engine #(
    .FRAMES_IN_BLOCK (FRAMES_IN_BLOCK),
    .BYTES_IN_FRAME  (BYTES_IN_FRAME)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .res   (eng_res)
  );

  // Result register: load on fire, drop valid once the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= eng_res;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.reply_kind    = out_item_r.reply_kind;
  assign out_if.reply_seq     = out_item_r.reply_seq;
  assign out_if.store_offset  = out_item_r.store_offset;
  assign out_if.store_len     = out_item_r.store_len;
  assign out_if.request_kind  = out_item_r.request_kind;
  assign out_if.write_len     = out_item_r.write_len;
  assign out_if.upload_active = out_item_r.upload_active;
  assign out_if.error_bits    = out_item_r.error_bits;
  assign out_if.next_seq      = out_item_r.next_seq;
  assign out_if.fill_count    = out_item_r.fill_count;
  assign out_if.block_count   = out_item_r.block_count;
  assign out_if.last_fault    = out_item_r.last_fault;

endmodule

/* rtl/core/sbur_engine.sv */
// Upload state registers and the per-item decision logic.
module sbur_engine #(
  parameter int FRAMES_IN_BLOCK = sbur_pkg::FRAMES_IN_BLOCK_DEF,
  parameter int BYTES_IN_FRAME  = sbur_pkg::BYTES_IN_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  sbur_pkg::in_item_t   item,
  output sbur_pkg::out_item_t  res
);

  localparam int BufBytes = FRAMES_IN_BLOCK * BYTES_IN_FRAME;
  localparam int FillW    = $clog2(BufBytes + 8);

  logic               active_r, active_nxt;
  logic [7:0]         expect_r, expect_nxt;
  logic [FillW-1:0]   fill_r, fill_nxt;
  logic [15:0]        blocks_r, blocks_nxt;
  logic [2:0]         flags_r, flags_nxt;
  logic [15:0]        fcode_r, fcode_nxt;
  sbur_pkg::pend_t    pend_r, pend_nxt;
  logic               prply_r, prply_nxt;

  logic [2:0]         plen;
  logic [FillW-1:0]   fill_sum;
  logic [7:0]         expect_inc;
  logic               match;

  // Payload bytes: length code capped at 8, minus the sequence byte.
  assign plen       = (item.frame_length > 4'd8) ? 3'd7 : 3'(item.frame_length - 4'd1);
  assign fill_sum   = fill_r + FillW'(plen);
  assign expect_inc = expect_r + 8'd1;
  assign match      = (pend_r == sbur_pkg::PEND_FINISH) ?
                      (item.action == sbur_pkg::ACT_FINISH) :
                      (item.action == sbur_pkg::ACT_WRITE);

  always_comb begin
    active_nxt = active_r;
    expect_nxt = expect_r;
    fill_nxt   = fill_r;
    blocks_nxt = blocks_r;
    flags_nxt  = flags_r;
    fcode_nxt  = fcode_r;
    pend_nxt   = pend_r;
    prply_nxt  = prply_r;

    res = '0;

    if (pend_r != sbur_pkg::PEND_NONE) begin
      if (match) begin
        pend_nxt  = sbur_pkg::PEND_NONE;
        prply_nxt = 1'b0;
        unique case (pend_r)
          sbur_pkg::PEND_BLOCK: begin
            fill_nxt   = '0;
            expect_nxt = '0;
            if (item.outcome_ok) begin
              blocks_nxt = blocks_r + 16'd1;
              flags_nxt[sbur_pkg::FLAG_WRITE] = 1'b0;
              fcode_nxt = '0;
              if (prply_r) res.reply_kind = sbur_pkg::RPL_ACK;
            end else begin
              flags_nxt[sbur_pkg::FLAG_WRITE] = 1'b1;
              fcode_nxt = item.outcome_code;
              if (prply_r) res.reply_kind = sbur_pkg::RPL_NACK;
            end
          end
          sbur_pkg::PEND_FINAL: begin
            if (item.outcome_ok) begin
              fill_nxt         = '0;
              expect_nxt       = '0;
              blocks_nxt       = blocks_r + 16'd1;
              res.request_kind = sbur_pkg::PEND_FINISH;
              pend_nxt         = sbur_pkg::PEND_FINISH;
            end else begin
              flags_nxt[sbur_pkg::FLAG_WRITE] = 1'b1;
              fcode_nxt      = item.outcome_code;
              res.reply_kind = sbur_pkg::RPL_NACK;
              res.reply_seq  = expect_r;
            end
          end
          default: begin
            if (item.outcome_ok) begin
              res.reply_kind = sbur_pkg::RPL_ACK;
              active_nxt     = 1'b0;
            end else begin
              flags_nxt[sbur_pkg::FLAG_WRITE] = 1'b1;
              fcode_nxt      = item.outcome_code;
              res.reply_kind = sbur_pkg::RPL_NACK;
              res.reply_seq  = expect_r;
            end
          end
        endcase
      end
    end else begin
      case (item.action)
        sbur_pkg::ACT_START: begin
          if (item.outcome_ok) begin
            active_nxt     = 1'b1;
            fill_nxt       = '0;
            expect_nxt     = '0;
            blocks_nxt     = '0;
            flags_nxt      = '0;
            fcode_nxt      = '0;
            res.reply_kind = sbur_pkg::RPL_ACK;
          end
        end
        sbur_pkg::ACT_DATA: begin
          if (!active_r) begin
            if (item.reply_wanted) res.reply_kind = sbur_pkg::RPL_NACK;
          end else if (item.frame_length == 4'd0) begin
            flags_nxt[sbur_pkg::FLAG_BAD] = 1'b1;
            if (item.reply_wanted) begin
              res.reply_kind = sbur_pkg::RPL_NACK;
              res.reply_seq  = expect_r;
            end
          end else if (item.seq_byte != expect_r) begin
            flags_nxt[sbur_pkg::FLAG_SEQ] = 1'b1;
            if (item.reply_wanted) begin
              res.reply_kind = sbur_pkg::RPL_NACK;
              res.reply_seq  = expect_r;
            end
          end else if (fill_sum > FillW'(BufBytes)) begin
            fill_nxt   = '0;
            expect_nxt = '0;
            flags_nxt[sbur_pkg::FLAG_BAD] = 1'b1;
            if (item.reply_wanted) res.reply_kind = sbur_pkg::RPL_NACK;
          end else begin
            res.store_offset = 10'(fill_r);
            res.store_len    = plen;
            fill_nxt         = fill_sum;
            expect_nxt       = expect_inc;
            flags_nxt[sbur_pkg::FLAG_SEQ] = 1'b0;
            flags_nxt[sbur_pkg::FLAG_BAD] = 1'b0;
            if (32'(expect_inc) >= FRAMES_IN_BLOCK) begin
              res.request_kind = sbur_pkg::PEND_BLOCK;
              res.write_len    = 10'(fill_sum);
              pend_nxt         = sbur_pkg::PEND_BLOCK;
              prply_nxt        = item.reply_wanted;
            end
          end
        end
        sbur_pkg::ACT_END: begin
          if (active_r) begin
            if (fill_r != '0) begin
              res.request_kind = sbur_pkg::PEND_FINAL;
              res.write_len    = 10'(fill_r);
              pend_nxt         = sbur_pkg::PEND_FINAL;
            end else begin
              res.request_kind = sbur_pkg::PEND_FINISH;
              pend_nxt         = sbur_pkg::PEND_FINISH;
            end
            prply_nxt = 1'b1;
          end
        end
        default: begin
          // Outcome with nothing pending, or an unknown action: status only.
        end
      endcase
    end

    res.upload_active = active_nxt;
    res.error_bits    = flags_nxt;
    res.next_seq      = expect_nxt;
    res.fill_count    = 10'(fill_nxt);
    res.block_count   = blocks_nxt;
    res.last_fault    = fcode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      expect_r <= '0;
      fill_r   <= '0;
      blocks_r <= '0;
      flags_r  <= '0;
      fcode_r  <= '0;
      pend_r   <= sbur_pkg::PEND_NONE;
      prply_r  <= 1'b0;
    end else if (fire) begin
      active_r <= active_nxt;
      expect_r <= expect_nxt;
      fill_r   <= fill_nxt;
      blocks_r <= blocks_nxt;
      flags_r  <= flags_nxt;
      fcode_r  <= fcode_nxt;
      pend_r   <= pend_nxt;
      prply_r  <= prply_nxt;
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the sequenced block upload receiver.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 360;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int BUFFER_BYTES  = sbur_pkg::FRAMES_IN_BLOCK_DEF * sbur_pkg::BYTES_IN_FRAME_DEF;

  // Upload state as the block is expected to hold it.
  typedef struct {
    bit              active;
    bit [7:0]        exp_num;
    int unsigned     fill;
    bit [15:0]       blocks;
    bit [2:0]        flags;
    bit [15:0]       fcode;
    sbur_pkg::pend_t pend;
    bit              pend_reply;
  } upload_state_t;

  logic clk;
  logic rst_n;

  sbur_in_if  in_if ();
  sbur_out_if out_if ();

  sequenced_block_upload_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Items waiting to be driven, results still owed by the block.
  sbur_pkg::in_item_t  frame_queue[$];
  sbur_pkg::out_item_t expected_results[$];
  // plan_state follows the stimulus as it is built, block_state follows the
  // items actually accepted by the block.
  upload_state_t plan_state;
  upload_state_t block_state;

  int fail_count;
  int results_seen;
  int idle_cycles;
  int send_wait;
  int send_calm;
  int take_wait;
  int take_calm;
  int work_items;

  always #CLK_HALF clk = ~clk;

  // Advance the upload state by one item and return the one result it gives.
  function automatic sbur_pkg::out_item_t upload_step(inout upload_state_t s,
                                                      input sbur_pkg::in_item_t it);
    sbur_pkg::out_item_t r;
    sbur_pkg::pend_t     done_kind;
    int unsigned         plen;
    r = '0;
    if (s.pend != sbur_pkg::PEND_NONE) begin
      // Only the outcome of the pending operation gets through.
      if ((s.pend == sbur_pkg::PEND_FINISH) ? (it.action == sbur_pkg::ACT_FINISH) :
                                              (it.action == sbur_pkg::ACT_WRITE)) begin
        done_kind = s.pend;
        s.pend = sbur_pkg::PEND_NONE;
        case (done_kind)
          sbur_pkg::PEND_BLOCK: begin
            s.fill = 0;
            s.exp_num = '0;
            if (it.outcome_ok) begin
              s.blocks++;
              s.flags[sbur_pkg::FLAG_WRITE] = 1'b0;
              s.fcode = '0;
              if (s.pend_reply) r.reply_kind = sbur_pkg::RPL_ACK;
            end else begin
              s.flags[sbur_pkg::FLAG_WRITE] = 1'b1;
              s.fcode = it.outcome_code;
              if (s.pend_reply) r.reply_kind = sbur_pkg::RPL_NACK;
            end
          end
          sbur_pkg::PEND_FINAL: begin
            if (it.outcome_ok) begin
              s.fill = 0;
              s.exp_num = '0;
              s.blocks++;
              r.request_kind = sbur_pkg::PEND_FINISH;
              s.pend = sbur_pkg::PEND_FINISH;
            end else begin
              s.flags[sbur_pkg::FLAG_WRITE] = 1'b1;
              s.fcode = it.outcome_code;
              r.reply_kind = sbur_pkg::RPL_NACK;
              r.reply_seq = s.exp_num;
            end
          end
          default: begin
            if (it.outcome_ok) begin
              r.reply_kind = sbur_pkg::RPL_ACK;
              s.active = 1'b0;
            end else begin
              s.flags[sbur_pkg::FLAG_WRITE] = 1'b1;
              s.fcode = it.outcome_code;
              r.reply_kind = sbur_pkg::RPL_NACK;
              r.reply_seq = s.exp_num;
            end
          end
        endcase
        s.pend_reply = 1'b0;
      end
    end else begin
      case (it.action)
        sbur_pkg::ACT_START: begin
          if (it.outcome_ok) begin
            s.active = 1'b1;
            s.fill = 0;
            s.exp_num = '0;
            s.blocks = '0;
            s.flags = '0;
            s.fcode = '0;
            r.reply_kind = sbur_pkg::RPL_ACK;
          end
        end
        sbur_pkg::ACT_DATA: begin
          if (!s.active) begin
            if (it.reply_wanted) r.reply_kind = sbur_pkg::RPL_NACK;
          end else if (it.frame_length == 0) begin
            s.flags[sbur_pkg::FLAG_BAD] = 1'b1;
            if (it.reply_wanted) begin
              r.reply_kind = sbur_pkg::RPL_NACK;
              r.reply_seq = s.exp_num;
            end
          end else if (it.seq_byte != s.exp_num) begin
            s.flags[sbur_pkg::FLAG_SEQ] = 1'b1;
            if (it.reply_wanted) begin
              r.reply_kind = sbur_pkg::RPL_NACK;
              r.reply_seq = s.exp_num;
            end
          end else begin
            // Length codes above 8 count as a full frame.
            plen = ((it.frame_length > 8) ? 8 : it.frame_length) - 1;
            if (s.fill + plen > BUFFER_BYTES) begin
              s.fill = 0;
              s.exp_num = '0;
              s.flags[sbur_pkg::FLAG_BAD] = 1'b1;
              if (it.reply_wanted) r.reply_kind = sbur_pkg::RPL_NACK;
            end else begin
              r.store_offset = 10'(s.fill);
              r.store_len = 3'(plen);
              s.fill += plen;
              s.exp_num++;
              s.flags[sbur_pkg::FLAG_SEQ] = 1'b0;
              s.flags[sbur_pkg::FLAG_BAD] = 1'b0;
              // Last frame of a block: ask for the write, hold the reply back.
              if (s.exp_num >= sbur_pkg::FRAMES_IN_BLOCK_DEF) begin
                r.request_kind = sbur_pkg::PEND_BLOCK;
                r.write_len = 10'(s.fill);
                s.pend = sbur_pkg::PEND_BLOCK;
                s.pend_reply = it.reply_wanted;
              end
            end
          end
        end
        sbur_pkg::ACT_END: begin
          if (s.active) begin
            if (s.fill > 0) begin
              r.request_kind = sbur_pkg::PEND_FINAL;
              r.write_len = 10'(s.fill);
              s.pend = sbur_pkg::PEND_FINAL;
            end else begin
              r.request_kind = sbur_pkg::PEND_FINISH;
              s.pend = sbur_pkg::PEND_FINISH;
            end
            s.pend_reply = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.upload_active = s.active;
    r.error_bits    = s.flags;
    r.next_seq      = s.exp_num;
    r.fill_count    = 10'(s.fill);
    r.block_count   = s.blocks;
    r.last_fault    = s.fcode;
    return r;
  endfunction

  // Draw the idle cycles before the next item, with calm stretches now and then.
  function automatic int pick_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic bit field_ok(string name, int unsigned want, int unsigned got);
    if (want != got)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return want == got;
  endfunction

  // Queue one item and follow it in the planning copy of the upload state.
  task automatic queue_frame(input logic [2:0] act, input bit want, input bit [3:0] len,
                             input bit [7:0] seq, input bit ok, input bit [15:0] code);
    sbur_pkg::in_item_t it;
    it = '{action: act, reply_wanted: want, frame_length: len, seq_byte: seq,
           outcome_ok: ok, outcome_code: code};
    frame_queue.push_back(it);
    void'(upload_step(plan_state, it));
  endtask

  // Driver: predict each accepted item, then offer the next one after its gap.
  always @(posedge clk) begin
    sbur_pkg::in_item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(upload_step(block_state, '{
          action: in_if.action, reply_wanted: in_if.reply_wanted,
          frame_length: in_if.frame_length, seq_byte: in_if.seq_byte,
          outcome_ok: in_if.outcome_ok, outcome_code: in_if.outcome_code}));
      end
      // Hold the offered item until the block takes it.
      if (!in_if.valid || in_if.ready) begin
        if (send_wait > 0) begin
          in_if.valid <= 1'b0;
          send_wait--;
        end else if (frame_queue.size() != 0) begin
          nxt = frame_queue.pop_front();
          in_if.action       <= nxt.action;
          in_if.reply_wanted <= nxt.reply_wanted;
          in_if.frame_length <= nxt.frame_length;
          in_if.seq_byte     <= nxt.seq_byte;
          in_if.outcome_ok   <= nxt.outcome_ok;
          in_if.outcome_code <= nxt.outcome_code;
          in_if.valid        <= 1'b1;
          send_wait = pick_wait(send_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random.
  always @(posedge clk) begin
    sbur_pkg::out_item_t got;
    sbur_pkg::out_item_t want;
    bit                  ok;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{reply_kind: out_if.reply_kind, reply_seq: out_if.reply_seq,
                store_offset: out_if.store_offset, store_len: out_if.store_len,
                request_kind: out_if.request_kind, write_len: out_if.write_len,
                upload_active: out_if.upload_active, error_bits: out_if.error_bits,
                next_seq: out_if.next_seq, fill_count: out_if.fill_count,
                block_count: out_if.block_count, last_fault: out_if.last_fault};
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          ok = field_ok("reply_kind", want.reply_kind, got.reply_kind)
             & field_ok("reply_seq", want.reply_seq, got.reply_seq)
             & field_ok("store_offset", want.store_offset, got.store_offset)
             & field_ok("store_len", want.store_len, got.store_len)
             & field_ok("request_kind", want.request_kind, got.request_kind)
             & field_ok("write_len", want.write_len, got.write_len)
             & field_ok("upload_active", want.upload_active, got.upload_active)
             & field_ok("error_bits", want.error_bits, got.error_bits)
             & field_ok("next_seq", want.next_seq, got.next_seq)
             & field_ok("fill_count", want.fill_count, got.fill_count)
             & field_ok("block_count", want.block_count, got.block_count)
             & field_ok("last_fault", want.last_fault, got.last_fault);
          if (!ok) fail_count++;
        end
        results_seen++;
        // Once in the run, hold off long enough for the block to back up.
        if (results_seen == HOLD_AT) take_wait = HOLD_CYCLES;
        else take_wait = pick_wait(take_calm);
      end
      if (take_wait > 0) begin
        out_if.ready <= 1'b0;
        take_wait--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          roll;
    int          frames_left;
    bit          full_frames;
    logic [2:0]  spare;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = sbur_pkg::ACT_START;
    in_if.reply_wanted = 1'b0;
    in_if.frame_length = '0;
    in_if.seq_byte = '0;
    in_if.outcome_ok = 1'b0;
    in_if.outcome_code = '0;
    out_if.ready = 1'b0;
    fail_count = 0;
    results_seen = 0;
    idle_cycles = 0;
    send_calm = 0;
    take_calm = 0;
    work_items = 0;
    plan_state = '{default: '0, pend: sbur_pkg::PEND_NONE};
    block_state = '{default: '0, pend: sbur_pkg::PEND_NONE};

    // Directed part: idle behavior, frame checks, every outcome both ways.
    queue_frame(sbur_pkg::ACT_START, 1, 4'd0, 8'd0, 0, 16'hFFFF);  // failed start
    queue_frame(sbur_pkg::ACT_DATA, 1, 4'd8, 8'd0, 0, 16'd0);      // data while idle, nack 0
    queue_frame(sbur_pkg::ACT_DATA, 0, 4'd15, 8'd255, 1, 16'd0);   // data while idle, silent
    queue_frame(sbur_pkg::ACT_END, 1, 4'd0, 8'd0, 0, 16'd0);       // end while idle
    queue_frame(sbur_pkg::ACT_WRITE, 1, 4'd0, 8'd0, 1, 16'd0);     // stray write outcome
    queue_frame(sbur_pkg::ACT_FINISH, 1, 4'd0, 8'd0, 1, 16'd0);    // stray finish outcome
    for (spare = 3'(sbur_pkg::ACT_FINISH + 1); spare != sbur_pkg::ACT_START; spare++)
      queue_frame(spare, 1, 4'd8, 8'd0, 1, 16'hFFFF);               // unknown actions
    queue_frame(sbur_pkg::ACT_START, 0, 4'd0, 8'd0, 1, 16'd0);     // start the upload
    queue_frame(sbur_pkg::ACT_DATA, 1, 4'd0, plan_state.exp_num, 0, 16'd0);  // empty frame
    queue_frame(sbur_pkg::ACT_DATA, 1, 4'd8, plan_state.exp_num + 8'd5, 0,
                16'd0);                                             // wrong sequence
    queue_frame(sbur_pkg::ACT_DATA, 1, 4'd15, plan_state.exp_num, 0, 16'd0); // overlong code
    queue_frame(sbur_pkg::ACT_DATA, 0, 4'd1, plan_state.exp_num, 0, 16'd0);  // no payload
    queue_frame(sbur_pkg::ACT_DATA, 1, 4'd8, plan_state.exp_num, 0, 16'd0);
    queue_frame(sbur_pkg::ACT_END, 0, 4'd0, 8'd0, 0, 16'd0);       // final partial write
    queue_frame(sbur_pkg::ACT_DATA, 1, 4'd8, plan_state.exp_num, 1,
                16'd0);                                             // ignored while pending
    queue_frame(sbur_pkg::ACT_FINISH, 1, 4'd0, 8'd0, 1, 16'd0);    // wrong outcome, ignored
    queue_frame(sbur_pkg::ACT_WRITE, 1, 4'd0, 8'd0, 0, 16'hA5A5);  // final write fails
    queue_frame(sbur_pkg::ACT_END, 1, 4'd0, 8'd0, 0, 16'd0);
    queue_frame(sbur_pkg::ACT_WRITE, 0, 4'd0, 8'd0, 1, 16'd0);     // final write ok
    queue_frame(sbur_pkg::ACT_START, 1, 4'd0, 8'd0, 1, 16'd0);     // ignored while pending
    queue_frame(sbur_pkg::ACT_FINISH, 0, 4'd0, 8'd0, 0, 16'h0001); // finish fails
    queue_frame(sbur_pkg::ACT_END, 0, 4'd0, 8'd0, 0, 16'd0);       // empty: finish at once
    queue_frame(sbur_pkg::ACT_FINISH, 0, 4'd0, 8'd0, 1, 16'hFFFF); // finish ok, upload ends

    // Random part: mostly well-formed uploads with random content, so that
    // whole blocks get written; a few broken frames, restarts and noise.
    frames_left = 0;
    full_frames = 1'b0;
    while (work_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        queue_frame(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      end else begin
        work_items++;
        if (plan_state.pend != sbur_pkg::PEND_NONE) begin
          queue_frame((plan_state.pend == sbur_pkg::PEND_FINISH) ? sbur_pkg::ACT_FINISH
                                                                  : sbur_pkg::ACT_WRITE,
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
                      16'($urandom_range(0, 65535)));
        end else if (!plan_state.active || roll < 6) begin
          // Start or restart; most uploads run past one whole block.
          queue_frame(sbur_pkg::ACT_START, 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 9) != 0, 16'($urandom_range(0, 65535)));
          frames_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30)
                                                    : $urandom_range(128, 200);
          full_frames = ($urandom_range(0, 2) == 0);
        end else if (frames_left == 0) begin
          queue_frame(sbur_pkg::ACT_END, 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        end else if (roll < 10) begin
          queue_frame(sbur_pkg::ACT_DATA, 1'($urandom_range(0, 1)), 4'd0,
                      plan_state.exp_num, 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)));
        end else if (roll < 14) begin
          queue_frame(sbur_pkg::ACT_DATA, 1'($urandom_range(0, 1)),
                      4'($urandom_range(1, 15)),
                      plan_state.exp_num + 8'($urandom_range(1, 255)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        end else begin
          queue_frame(sbur_pkg::ACT_DATA, 1'($urandom_range(0, 1)),
                      full_frames ? 4'($urandom_range(8, 15)) : 4'($urandom_range(1, 15)),
                      plan_state.exp_num, 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)));
          frames_left--;
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to go in and every result to come back.
    @(negedge clk);
    while (frame_queue.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sbur_pkg.sv
rtl/core/sbur_if.sv
rtl/core/sbur_engine.sv
rtl/core/sequenced_block_upload_receiver.sv
tb/tb_top.sv
